>>> src/parallel_iterative_matcher_defines.svh
// Assertion macros shared by the matcher checker.
`ifndef PARALLEL_ITERATIVE_MATCHER_DEFINES_SVH
`define PARALLEL_ITERATIVE_MATCHER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define PIM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("matcher check failed: same-cycle rule");

// Next-cycle implication, held off during reset.
`define PIM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("matcher check failed: next-cycle rule");

`endif

>>> src/pim_pkg.sv
// Shared constants, register codes and helper functions of the matcher.
`default_nettype none

package pim_pkg;

    localparam int PORTS_DEFAULT = 8;
    localparam int PORTS_CFG_MAX = 15;
    localparam int SRC_W         = 3;
    localparam int MASK_W        = 8;
    localparam int CNT_W         = 4;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 1;
    localparam int PORTS_W       = 4;
    localparam int LFSR_W        = 16;

    localparam logic [PORTS_W-1:0] PORTS_RST    = 4'd8;
    localparam logic [LFSR_W-1:0]  SEED_DEFAULT = 16'hACE1;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS    = 16'hB400;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORTS_IN_USE = 1'b0,
        CFG_LFSR_SEED    = 1'b1
    } t_cfg_idx;

    // One Galois step: shift right, fold taps in when a one falls out.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ LFSR_TAPS;
        end
        return r;
    endfunction

    // Eight restoring remainder steps; rem must already be below c.
    function automatic logic [CNT_W-1:0] rem_step8(input logic [CNT_W-1:0] rem,
                                                   input logic [7:0] b,
                                                   input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] t;
        t = rem;
        for (int i = 7; i >= 0; i--) begin
            t = {t[CNT_W-2:0], b[i]};
            if (t >= c) begin
                t = t - c;
            end
        end
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] popcount8(input logic [MASK_W-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int j = 0; j < MASK_W; j++) begin
            n = n + CNT_W'(v[j]);
        end
        return n;
    endfunction

    // Position of the k-th set bit, counting up from bit 0.
    function automatic logic [SRC_W-1:0] select_kth(input logic [MASK_W-1:0] v,
                                                    input logic [SRC_W-1:0] k);
        logic [SRC_W-1:0] idx;
        logic [SRC_W-1:0] seen;
        logic             found;
        idx   = '0;
        seen  = '0;
        found = 1'b0;
        for (int j = 0; j < MASK_W; j++) begin
            if (v[j] && !found) begin
                if (seen == k) begin
                    idx   = SRC_W'(j);
                    found = 1'b1;
                end else begin
                    seen = seen + SRC_W'(1);
                end
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> src/parallel_iterative_matcher.sv
// Parallel iterative matcher: request store, grant/accept sequencer, shared draw unit.
//
// Usage: pulse i_start with a request row (source, mask, last flag) while o_busy is
// low; each accepted beat from an in-use source stores its row; the block stays free.
// A beat with i_last_row set stores its row, then o_busy rises for one
// request-grant-accept round. Config writes (i_cfg_we) must go in while o_busy is
// low; the block itself does not enforce this. Grant phase, per destination: a
// scan only when nobody requests it, else a scan (step LFSR and count), two
// remainder passes and a pick of the requester. Accept phase, per source: a scan
// only with zero or one grant, else the same draw steps. The shared remainder unit
// works 8 bits of the 16-bit draw per cycle and serves all grant and accept draws.
// Results: one beat per active source, ascending, each on o_valid for exactly
// one cycle; o_last_result marks the last. o_busy falls with the last beat.
// The receiver cannot stall; every beat must be taken as it appears.
// Reset (i_rst_n low, synchronous): request and grant stores cleared, 8 ports
// in use, LFSR loaded with 0xACE1, sequencer idle.
`default_nettype none

module parallel_iterative_matcher #(
    parameter int PORTS = pim_pkg::PORTS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [pim_pkg::SRC_W-1:0]     i_src_port,
    input  logic [pim_pkg::MASK_W-1:0]    i_request_mask,
    input  logic                          i_last_row,
    output logic                          o_valid,
    output logic [pim_pkg::SRC_W-1:0]     o_out_src,
    output logic                          o_matched,
    output logic [pim_pkg::SRC_W-1:0]     o_match_dst,
    output logic                          o_last_result,
    input  logic                          i_cfg_we,
    input  logic [pim_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pim_pkg::CFG_W-1:0]     i_cfg_data
);
    import pim_pkg::*;

    // Only sources 0..7 can carry a row, so at most eight rows are stored.
    localparam int ROWS = (PORTS < MASK_W) ? PORTS : MASK_W;
    localparam int RW   = $clog2(ROWS);
    // Largest active port count: 4-bit register clamped to PORTS.
    localparam int NMAX = (PORTS < PORTS_CFG_MAX) ? PORTS : PORTS_CFG_MAX;
    localparam int NW   = $clog2(NMAX + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GSCAN,    // look at destination r_d
        S_DIV_HI,   // remainder, upper byte of draw
        S_DIV_LO,   // remainder, lower byte of draw
        S_PICK,     // select the drawn position
        S_ASCAN     // look at source r_s
    } t_state;

    t_state              r_state;
    logic [PORTS_W-1:0]  r_ports;
    logic [LFSR_W-1:0]   r_lfsr;
    logic [MASK_W-1:0]   r_req [ROWS];
    logic [MASK_W-1:0]   r_gnt [ROWS];
    logic [NW-1:0]       r_d;
    logic [NW-1:0]       r_s;
    logic                r_accept;     // draw belongs to accept phase

    // draw unit operands
    logic [LFSR_W-1:0]   r_div;
    logic [MASK_W-1:0]   r_vec;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_rem;

    logic [NW-1:0]       w_n;
    logic [MASK_W-1:0]   w_live;
    logic [MASK_W-1:0]   w_col;
    logic [CNT_W-1:0]    w_col_cnt;
    logic [MASK_W-1:0]   w_grow;
    logic [CNT_W-1:0]    w_grow_cnt;
    logic [LFSR_W-1:0]   w_lfsr_nx;
    logic [SRC_W-1:0]    w_pick;
    logic [SRC_W-1:0]    w_single;
    logic                w_d_last;
    logic                w_s_last;
    logic                w_src_ok;
    logic                w_take;

    assign o_busy = (r_state != S_IDLE);
    assign w_take = i_start && !o_busy;

    // active port count, clamped to 1..NMAX
    always_comb begin
        int pv;
        pv = int'(r_ports);
        if (pv < 1) begin
            pv = 1;
        end
        if (pv > NMAX) begin
            pv = NMAX;
        end
        w_n = NW'(pv);
    end

    always_comb begin
        for (int j = 0; j < MASK_W; j++) begin
            w_live[j] = (j < int'(w_n));
        end
    end

    // column r_d of the request store: which active sources ask for this destination
    always_comb begin
        w_col = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int j = 0; j < MASK_W; j++) begin
                if (int'(r_d) == j) begin
                    w_col[r] = r_req[r][j] && w_live[r];
                end
            end
        end
    end

    assign w_grow     = (int'(r_s) < ROWS) ? r_gnt[r_s[RW-1:0]] : '0;
    assign w_col_cnt  = popcount8(w_col);
    assign w_grow_cnt = popcount8(w_grow);
    assign w_lfsr_nx  = lfsr_next(r_lfsr);
    assign w_pick     = select_kth(r_vec, r_rem[SRC_W-1:0]);
    assign w_single   = select_kth(w_grow, '0);
    assign w_d_last   = (r_d == w_n - NW'(1));
    assign w_s_last   = (r_s == w_n - NW'(1));
    assign w_src_ok   = (int'(i_src_port) < int'(w_n));

    // sequencer, stores and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ports  <= PORTS_RST;
            r_lfsr   <= SEED_DEFAULT;
            r_d      <= '0;
            r_s      <= '0;
            r_accept <= 1'b0;
            o_valid  <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                r_req[r] <= '0;
                r_gnt[r] <= '0;
            end
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        if (w_src_ok) begin
                            r_req[i_src_port[RW-1:0]] <= i_request_mask & w_live;
                        end
                        if (i_last_row) begin
                            for (int r = 0; r < ROWS; r++) begin
                                r_gnt[r] <= '0;
                            end
                            r_d     <= '0;
                            r_state <= S_GSCAN;
                        end
                    end
                end
                S_GSCAN: begin
                    if (w_col_cnt != '0) begin
                        r_lfsr   <= w_lfsr_nx;
                        r_accept <= 1'b0;
                        r_state  <= S_DIV_HI;
                    end else if (w_d_last) begin
                        r_s     <= '0;
                        r_state <= S_ASCAN;
                    end else begin
                        r_d <= r_d + NW'(1);
                    end
                end
                S_DIV_HI: begin
                    r_state <= S_DIV_LO;
                end
                S_DIV_LO: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (!r_accept) begin
                        for (int j = 0; j < MASK_W; j++) begin
                            if (int'(r_d) == j) begin
                                r_gnt[w_pick[RW-1:0]][j] <= 1'b1;
                            end
                        end
                        if (w_d_last) begin
                            r_s     <= '0;
                            r_state <= S_ASCAN;
                        end else begin
                            r_d     <= r_d + NW'(1);
                            r_state <= S_GSCAN;
                        end
                    end else begin
                        o_valid <= 1'b1;
                        if (w_s_last) begin
                            for (int r = 0; r < ROWS; r++) begin
                                r_req[r] <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_s     <= r_s + NW'(1);
                            r_state <= S_ASCAN;
                        end
                    end
                end
                S_ASCAN: begin
                    if (w_grow_cnt > CNT_W'(1)) begin
                        r_lfsr   <= w_lfsr_nx;
                        r_accept <= 1'b1;
                        r_state  <= S_DIV_HI;
                    end else begin
                        o_valid <= 1'b1;
                        if (w_s_last) begin
                            for (int r = 0; r < ROWS; r++) begin
                                r_req[r] <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            r_s <= r_s + NW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // config writes must arrive only while idle; the block itself does not enforce this
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PORTS_IN_USE: begin
                        r_ports <= i_cfg_data[PORTS_W-1:0];
                    end
                    CFG_LFSR_SEED: begin
                        r_lfsr <= (i_cfg_data[LFSR_W-1:0] == '0) ? SEED_DEFAULT
                                                                 : i_cfg_data[LFSR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // draw unit operands and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_GSCAN: begin
                r_div <= w_lfsr_nx;
                r_vec <= w_col;
                r_cnt <= w_col_cnt;
            end
            S_DIV_HI: begin
                r_rem <= rem_step8('0, r_div[LFSR_W-1:8], r_cnt);
            end
            S_DIV_LO: begin
                r_rem <= rem_step8(r_rem, r_div[7:0], r_cnt);
            end
            S_PICK: begin
                if (r_accept) begin
                    o_out_src     <= SRC_W'(r_s);
                    o_matched     <= 1'b1;
                    o_match_dst   <= w_pick;
                    o_last_result <= w_s_last;
                end
            end
            S_ASCAN: begin
                if (w_grow_cnt > CNT_W'(1)) begin
                    r_div <= w_lfsr_nx;
                    r_vec <= w_grow;
                    r_cnt <= w_grow_cnt;
                end else begin
                    o_out_src     <= SRC_W'(r_s);
                    o_matched     <= (w_grow_cnt == CNT_W'(1));
                    o_match_dst   <= (w_grow_cnt == CNT_W'(1)) ? w_single : '0;
                    o_last_result <= w_s_last;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/pim_checker.sv
// Port-level checker for the matcher, bound to the top level.
`default_nettype none
`include "parallel_iterative_matcher_defines.svh"

module pim_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          i_last_row,
    input logic                          o_valid,
    input logic                          o_matched,
    input logic [pim_pkg::SRC_W-1:0]     o_match_dst,
    input logic                          o_last_result
);

    // a taken row beat never coincides with result emission next cycle
    `PIM_ASSERT_NEXT(a_take_quiet, i_clk, i_rst_n, i_start && !o_busy, !o_valid)
    // a last row starts a round
    `PIM_ASSERT_NEXT(a_last_busy, i_clk, i_rst_n, i_start && !o_busy && i_last_row, o_busy)
    // the block is idle while the last beat is out
    `PIM_ASSERT_NOW(a_end_idle, i_clk, i_rst_n, o_valid && o_last_result, !o_busy)
    // the round is still running while an earlier beat is out
    `PIM_ASSERT_NOW(a_mid_busy, i_clk, i_rst_n, o_valid && !o_last_result, o_busy)
    // unmatched sources report destination zero
    `PIM_ASSERT_NOW(a_unmatched_zero, i_clk, i_rst_n, o_valid && !o_matched, o_match_dst == '0)

endmodule

bind parallel_iterative_matcher pim_checker u_pim_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .i_last_row    (i_last_row),
    .o_valid       (o_valid),
    .o_matched     (o_matched),
    .o_match_dst   (o_match_dst),
    .o_last_result (o_last_result)
);

`default_nettype wire
